[src/ptls_pkg.sv]
// Shared types and constants for the process table lottery scheduler.
// Holds request and response payload types, code enums and default sizes.
// No dependencies.
package ptls_pkg;

  // Default sizes, handed down through the top-level parameters.
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PID_BITS_DEF      = 16;
  localparam int TICKET_BITS_DEF   = 16;

  // Fixed field widths of the request and response payloads.
  localparam int FPID_W     = 16;
  localparam int CH_W       = 16;
  localparam int TV_W       = 16;
  localparam int RND_W      = 31;
  localparam int SLICE_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH = 2'd1;

  // Reset values.
  localparam logic [SLICE_W-1:0] SLICE_LENGTH_RST = 8'd10;
  localparam int                 BASE_TICKETS_RST = 10;
  localparam int                 NEXT_ID_RST      = 2;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_FORK        = 3'd1,
    REQ_EXIT        = 3'd2,
    REQ_WAIT        = 3'd3,
    REQ_SLEEP       = 3'd4,
    REQ_WAKEUP      = 3'd5,
    REQ_KILL        = 3'd6,
    REQ_SET_TICKETS = 3'd7
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_NOT_FOUND        = 3'd1,
    ST_NO_CHILDREN      = 3'd2,
    ST_CHILDREN_RUNNING = 3'd3,
    ST_INIT_EXIT        = 3'd4,
    ST_BAD_TICKETS      = 3'd5,
    ST_TABLE_FULL       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    LIFE_UNUSED   = 3'd0,
    LIFE_EMBRYO   = 3'd1,
    LIFE_SLEEPING = 3'd2,
    LIFE_RUNNABLE = 3'd3,
    LIFE_RUNNING  = 3'd4,
    LIFE_ZOMBIE   = 3'd5
  } life_t;

  typedef struct packed {
    req_code_t         req_type;
    logic [FPID_W-1:0] target_pid;
    logic [CH_W-1:0]   channel;
    logic [TV_W-1:0]   ticket_value;
    logic [RND_W-1:0]  random_value;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [FPID_W-1:0] result_pid;
    logic [FPID_W-1:0] running_pid;
    logic              drew_lottery;
  } rsp_t;

endpackage

[src/ptls_table.sv]
// Process table memory: one write port, one read port, registered read data.
// Entries never written since reset read as their reset value (valid bits).
// Depends on ptls_pkg.
module ptls_table
  import ptls_pkg::*;
#(
  parameter int               DEPTH = TABLE_ENTRIES_DEF,
  parameter int               WIDTH = 8,
  parameter logic [WIDTH-1:0] INIT0 = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] ram [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] ram_q;
  logic             valid_q;
  logic             slot0_q;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q <= ram[rd_addr];
    end
  end

  // Valid bits and read qualifiers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      slot0_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
        slot0_q <= (rd_addr == '0);
      end
    end
  end

  // An entry not yet written shows its reset contents.
  assign rd_data = valid_q ? ram_q : (slot0_q ? INIT0 : '0);

endmodule

[src/ptls_mod.sv]
// Iterative remainder unit: one restoring step per cycle over the dividend bits.
// Used for the lottery draw. Depends on ptls_pkg.
module ptls_mod
  import ptls_pkg::*;
#(
  parameter int DW = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [DW-1:0]    remainder
);

  localparam int CNT_W = $clog2(RND_W + 1);

  logic [RND_W-1:0] dvd;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {remainder, dvd[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        dvd       <= dividend;
        dsr       <= divisor;
        remainder <= '0;
        cnt       <= CNT_W'(RND_W);
      end else if (busy) begin
        dvd <= dvd << 1;
        if (trial >= {1'b0, dsr}) begin
          remainder <= DW'(trial - {1'b0, dsr});
        end else begin
          remainder <= trial[DW-1:0];
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/process_table_lottery_scheduler_core.sv]
// Process table with a lottery scheduler. One request is taken at a time and
// answered with one response. All table state lives in a single memory with
// one read and one write port, so requests read and update it in walks over
// all TABLE_ENTRIES slots. A tick before its slice runs out makes no walk;
// kill and set-tickets make one walk; a tick that draws makes two, around the
// 31-step remainder unit; fork, sleep and wakeup make three; exit and a
// sleeping wait make four. Failed requests and reaping waits skip the draw.
// A response still stalled at the output holds the next one back. A new
// request may be taken while the previous response still waits. Writes to the
// initial ticket register are taken but have no effect after reset.
// Depends on ptls_pkg, ptls_table and ptls_mod.
module process_table_lottery_scheduler_core
  import ptls_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int PID_BITS      = PID_BITS_DEF,
  parameter int TICKET_BITS   = TICKET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int PAR_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int TOT_W  = TICKET_BITS + SLOT_W;
  localparam int CMP_W  = (PID_BITS > FPID_W) ? PID_BITS : FPID_W;
  localparam int SAT_W  = (TICKET_BITS > TV_W) ? TICKET_BITS : TV_W;
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;
  localparam logic [TICKET_BITS-1:0] TICKETS0 =
    (longint'(BASE_TICKETS_RST) > longint'(TICKET_MAX)) ?
    TICKET_MAX : TICKET_BITS'(BASE_TICKETS_RST);

  typedef struct packed {
    logic [PID_BITS-1:0]    pid;
    life_t                  life;
    logic [PAR_W-1:0]       parent;
    logic [TICKET_BITS-1:0] tickets;
    logic                   killed;
    logic [CH_W-1:0]        channel;
  } entry_t;

  localparam int     ENT_W = $bits(entry_t);
  localparam entry_t INIT0 = '{pid: PID_BITS'(1), life: LIFE_RUNNING, parent: '0,
                               tickets: TICKETS0, killed: 1'b0, channel: '0};

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_PAR_RD, S_PAR_WT, S_EXIT, S_WAIT, S_WAKE, S_APPLY,
    S_SUM, S_MOD, S_WALK, S_RUN_RD, S_RUN_WT, S_DONE
  } state_t;

  state_t                 state;
  req_t                   rq;
  logic [CNT_W-1:0]       issue_cnt;
  logic                   proc_vld;
  logic [SLOT_W-1:0]      proc_idx;
  logic [SLOT_W-1:0]      cur_slot;
  logic [SLICE_W-1:0]     slice_left;
  logic [SLICE_W-1:0]     slice_length;
  logic [PID_BITS-1:0]    next_id;
  logic                   s_found;
  logic [SLOT_W-1:0]      s_idx;
  entry_t                 s_ent;
  logic                   c_found;
  logic [SLOT_W-1:0]      c_idx;
  entry_t                 c_ent;
  logic                   kids;
  logic                   par_ok;
  logic [CH_W-1:0]        wch;
  logic [SLOT_W-1:0]      ap_addr;
  entry_t                 ap_data;
  logic                   do_draw;
  status_t                status_q;
  logic [FPID_W-1:0]      rpid_q;
  logic [FPID_W-1:0]      runpid_q;
  logic [TOT_W-1:0]       total;
  logic [TOT_W-1:0]       w;
  logic                   won;
  logic                   drew;
  logic                   mod_start;

  // Memory and remainder unit connections.
  logic                   tbl_rd_en;
  logic [SLOT_W-1:0]      tbl_rd_addr;
  logic [ENT_W-1:0]       tbl_rd_data;
  logic                   tbl_wr_en;
  logic [SLOT_W-1:0]      tbl_wr_addr;
  entry_t                 tbl_wr_data;
  logic                   mod_done;
  logic [TOT_W-1:0]       mod_rem;

  // Per-entry walk logic.
  entry_t                 e;
  entry_t                 ne;
  logic                   is_scan;
  logic                   issue;
  logic                   pass_last;
  logic [PAR_W-1:0]       s_par;
  logic                   pid_hit;
  logic                   kid;
  logic                   s_hit;
  logic                   s_fnd_n;
  logic [SLOT_W-1:0]      s_idx_n;
  entry_t                 s_ent_n;
  logic                   c_hit;
  logic                   c_fnd_n;
  logic [SLOT_W-1:0]      c_idx_n;
  entry_t                 c_ent_n;
  logic                   kids_n;
  logic                   sum_add;
  logic [TOT_W-1:0]       total_n;
  logic                   walk_el;
  logic                   win_hit;
  logic [TOT_W-1:0]       w_n;
  logic [PID_BITS-1:0]    p_alloc;
  logic [TICKET_BITS-1:0] tv_sat;
  logic                   par_ok_n;
  entry_t                 child_ent;
  entry_t                 sleep_ent;
  entry_t                 kill_ent;
  entry_t                 tick_ent;
  entry_t                 reap_ent;
  entry_t                 wsleep_ent;

  ptls_table #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENT_W),
    .INIT0 (INIT0)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  ptls_mod #(
    .DW (TOT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rq.random_value),
    .divisor   (total),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign e         = entry_t'(tbl_rd_data);
  assign is_scan   = (state == S_FIND) || (state == S_EXIT) || (state == S_WAIT) ||
                     (state == S_WAKE) || (state == S_SUM) || (state == S_WALK);
  assign issue     = is_scan && (issue_cnt < CNT_W'(TABLE_ENTRIES));
  assign pass_last = proc_vld && (proc_idx == SLOT_W'(TABLE_ENTRIES - 1));
  assign s_par     = PAR_W'(s_idx) + PAR_W'(1);

  // Entry update for the passes that modify the table.
  always_comb begin
    ne = e;
    unique case (state)
      S_EXIT: begin
        if (par_ok && e.life == LIFE_SLEEPING && e.channel == wch) begin
          ne.life = LIFE_RUNNABLE;
        end
        if (ne.life != LIFE_UNUSED && ne.parent == s_par) begin
          ne.parent = PAR_W'(1);
          ne.life   = LIFE_ZOMBIE;
        end
        if (proc_idx == s_idx) begin
          ne.life = LIFE_ZOMBIE;
        end
      end
      S_WAKE: begin
        if (e.life == LIFE_SLEEPING && e.channel == rq.channel) begin
          ne.life = LIFE_RUNNABLE;
        end
      end
      S_SUM: begin
        if (proc_idx == cur_slot && e.life == LIFE_RUNNING) begin
          ne.life = LIFE_RUNNABLE;
        end
      end
      S_WALK: begin
        if (win_hit) begin
          ne.life = LIFE_RUNNING;
        end
      end
      default: begin
      end
    endcase
  end

  // Searches and sums over the walk.
  always_comb begin
    pid_hit = (e.life != LIFE_UNUSED) && (rq.target_pid != '0) &&
              (CMP_W'(e.pid) == CMP_W'(rq.target_pid));
    kid     = (e.life != LIFE_UNUSED) && (e.parent == s_par);
    s_hit   = (state == S_FIND) && proc_vld && !s_found && pid_hit;
    s_fnd_n = s_found || s_hit;
    s_idx_n = s_hit ? proc_idx : s_idx;
    s_ent_n = s_hit ? e : s_ent;
    c_hit   = proc_vld && !c_found &&
              (((state == S_FIND) && (rq.req_type == REQ_FORK) &&
                e.life == LIFE_UNUSED) ||
               ((state == S_WAIT) && kid && e.life == LIFE_ZOMBIE));
    c_fnd_n = c_found || c_hit;
    c_idx_n = c_hit ? proc_idx : c_idx;
    c_ent_n = c_hit ? e : c_ent;
    kids_n  = kids || ((state == S_WAIT) && proc_vld && kid);
    sum_add = (state == S_SUM) && proc_vld && (ne.pid != '0) && !ne.killed &&
              (ne.life == LIFE_RUNNABLE || ne.life == LIFE_RUNNING);
    total_n = total + (sum_add ? TOT_W'(ne.tickets) : TOT_W'(0));
    walk_el = (state == S_WALK) && proc_vld && !won && e.life == LIFE_RUNNABLE && !e.killed;
    win_hit = walk_el && (w < TOT_W'(e.tickets));
    w_n     = (walk_el && !win_hit) ? (w - TOT_W'(e.tickets)) : w;
  end

  // Single-entry results of the request decisions.
  always_comb begin
    p_alloc  = (next_id == '0) ? PID_BITS'(1) : next_id;
    tv_sat   = (SAT_W'(rq.ticket_value) > SAT_W'(TICKET_MAX)) ?
               TICKET_MAX : TICKET_BITS'(rq.ticket_value);
    par_ok_n = (s_ent_n.parent != '0) && (s_ent_n.parent <= PAR_W'(TABLE_ENTRIES));

    child_ent         = '0;
    child_ent.pid     = p_alloc;
    child_ent.life    = LIFE_RUNNABLE;
    child_ent.parent  = PAR_W'(s_idx_n) + PAR_W'(1);
    child_ent.tickets = s_ent_n.tickets;

    sleep_ent         = s_ent_n;
    sleep_ent.channel = rq.channel;
    sleep_ent.life    = LIFE_SLEEPING;

    kill_ent          = s_ent_n;
    kill_ent.killed   = 1'b1;
    if (s_ent_n.life == LIFE_SLEEPING) begin
      kill_ent.life = LIFE_RUNNABLE;
    end

    tick_ent          = s_ent_n;
    tick_ent.tickets  = tv_sat;

    reap_ent          = c_ent_n;
    reap_ent.life     = LIFE_UNUSED;
    reap_ent.pid      = '0;
    reap_ent.parent   = '0;
    reap_ent.killed   = 1'b0;

    wsleep_ent         = s_ent;
    wsleep_ent.channel = CH_W'(s_ent.pid);
    wsleep_ent.life    = LIFE_SLEEPING;
  end

  // Memory port steering.
  always_comb begin
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = issue_cnt[SLOT_W-1:0];
    if (issue) begin
      tbl_rd_en = 1'b1;
    end else if (state == S_PAR_RD) begin
      tbl_rd_en   = 1'b1;
      tbl_rd_addr = SLOT_W'(s_ent.parent - PAR_W'(1));
    end else if (state == S_RUN_RD) begin
      tbl_rd_en   = 1'b1;
      tbl_rd_addr = cur_slot;
    end
    if (state == S_APPLY) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = ap_addr;
      tbl_wr_data = ap_data;
    end else begin
      tbl_wr_en   = is_scan && proc_vld && (ne != e);
      tbl_wr_addr = proc_idx;
      tbl_wr_data = ne;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= SLICE_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLICE_LENGTH: slice_length <= cfg_data[SLICE_W-1:0];
        CFG_BASE_TICKETS: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_cnt  <= '0;
      proc_vld   <= 1'b0;
      cur_slot   <= '0;
      slice_left <= '0;
      next_id    <= PID_BITS'(NEXT_ID_RST);
      mod_start  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // The remainder unit starts once the ticket total is final and nonzero.
      mod_start <= (state == S_SUM) && pass_last && (total_n != '0);

      // Walk pipeline: address issue, then entry processing on the registered read data.
      if (is_scan && !pass_last) begin
        issue_cnt <= issue_cnt + (issue ? CNT_W'(1) : CNT_W'(0));
        proc_vld  <= issue;
        proc_idx  <= issue_cnt[SLOT_W-1:0];
      end else begin
        issue_cnt <= '0;
        proc_vld  <= 1'b0;
      end
      if (is_scan) begin
        s_found <= s_fnd_n;
        s_idx   <= s_idx_n;
        s_ent   <= s_ent_n;
        c_found <= c_fnd_n;
        c_idx   <= c_idx_n;
        c_ent   <= c_ent_n;
        kids    <= kids_n;
        total   <= total_n;
        w       <= w_n;
        won     <= won || win_hit;
        if (win_hit) begin
          cur_slot <= proc_idx;
        end
      end

      // Output register drains when the consumer takes the transfer, unless
      // a new response is loaded in the same cycle.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            rq       <= req;
            status_q <= ST_OK;
            rpid_q   <= '0;
            drew     <= 1'b0;
            do_draw  <= 1'b0;
            s_found  <= 1'b0;
            c_found  <= 1'b0;
            kids     <= 1'b0;
            won      <= 1'b0;
            total    <= '0;
            unique case (req.req_type)
              REQ_TICK: begin
                if (slice_left <= SLICE_W'(1)) begin
                  state <= S_SUM;
                end else begin
                  slice_left <= slice_left - SLICE_W'(1);
                  state      <= S_RUN_RD;
                end
              end
              REQ_WAKEUP: state <= S_WAKE;
              REQ_SET_TICKETS: begin
                if (req.ticket_value == '0) begin
                  status_q <= ST_BAD_TICKETS;
                  state    <= S_RUN_RD;
                end else begin
                  state <= S_FIND;
                end
              end
              REQ_FORK, REQ_EXIT, REQ_WAIT, REQ_SLEEP, REQ_KILL: state <= S_FIND;
              default: state <= S_FIND;
            endcase
          end
        end

        S_FIND: begin
          if (pass_last) begin
            if (!s_fnd_n) begin
              status_q <= ST_NOT_FOUND;
              state    <= S_RUN_RD;
            end else begin
              unique case (rq.req_type)
                REQ_FORK: begin
                  if (!c_fnd_n) begin
                    status_q <= ST_TABLE_FULL;
                    state    <= S_RUN_RD;
                  end else begin
                    next_id <= p_alloc + PID_BITS'(1);
                    rpid_q  <= FPID_W'(p_alloc);
                    ap_addr <= c_idx_n;
                    ap_data <= child_ent;
                    do_draw <= 1'b1;
                    state   <= S_APPLY;
                  end
                end
                REQ_EXIT: begin
                  par_ok <= par_ok_n;
                  if (s_idx_n == '0) begin
                    status_q <= ST_INIT_EXIT;
                    state    <= S_RUN_RD;
                  end else if (par_ok_n) begin
                    state <= S_PAR_RD;
                  end else begin
                    state <= S_EXIT;
                  end
                end
                REQ_WAIT: state <= S_WAIT;
                REQ_SLEEP: begin
                  ap_addr <= s_idx_n;
                  ap_data <= sleep_ent;
                  do_draw <= 1'b1;
                  state   <= S_APPLY;
                end
                REQ_KILL: begin
                  ap_addr <= s_idx_n;
                  ap_data <= kill_ent;
                  state   <= S_APPLY;
                end
                REQ_SET_TICKETS: begin
                  ap_addr <= s_idx_n;
                  ap_data <= tick_ent;
                  state   <= S_APPLY;
                end
                default: state <= S_RUN_RD;
              endcase
            end
          end
        end

        S_PAR_RD: state <= S_PAR_WT;

        S_PAR_WT: begin
          wch   <= CH_W'(e.pid);
          state <= S_EXIT;
        end

        S_EXIT: begin
          if (pass_last) begin
            state <= S_SUM;
          end
        end

        S_WAIT: begin
          if (pass_last) begin
            if (c_fnd_n) begin
              rpid_q  <= FPID_W'(c_ent_n.pid);
              ap_addr <= c_idx_n;
              ap_data <= reap_ent;
              state   <= S_APPLY;
            end else if (!kids_n || s_ent.killed) begin
              status_q <= ST_NO_CHILDREN;
              state    <= S_RUN_RD;
            end else begin
              status_q <= ST_CHILDREN_RUNNING;
              ap_addr  <= s_idx;
              ap_data  <= wsleep_ent;
              do_draw  <= 1'b1;
              state    <= S_APPLY;
            end
          end
        end

        S_WAKE: begin
          if (pass_last) begin
            state <= S_SUM;
          end
        end

        S_APPLY: state <= do_draw ? S_SUM : S_RUN_RD;

        // Ticket total, with the running entry put back to runnable.
        S_SUM: begin
          if (pass_last) begin
            slice_left <= slice_length;
            if (total_n == '0) begin
              state <= S_RUN_RD;
            end else begin
              state <= S_MOD;
            end
          end
        end

        S_MOD: begin
          if (mod_done) begin
            w     <= mod_rem;
            state <= S_WALK;
          end
        end

        S_WALK: begin
          if (pass_last) begin
            drew  <= won || win_hit;
            state <= S_RUN_RD;
          end
        end

        S_RUN_RD: state <= S_RUN_WT;

        S_RUN_WT: begin
          runpid_q <= (e.life == LIFE_RUNNING) ? FPID_W'(e.pid) : '0;
          state    <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= status_q;
            rsp.result_pid   <= rpid_q;
            rsp.running_pid  <= runpid_q;
            rsp.drew_lottery <= drew;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/process_table_lottery_scheduler_core_test.sv]
// Testbench for the process table lottery scheduler core.
// Drives request and configuration transfers and checks every response against a predictor.
// Depends on ptls_pkg and process_table_lottery_scheduler_core.
`timescale 1ns / 100ps

module process_table_lottery_scheduler_core_test;
  import ptls_pkg::*;

  localparam int SLOTS = 64;

  // Predicts the table state and holds the expected responses in order.
  class sched_scoreboard;
    bit [15:0] pid_tab[SLOTS];
    life_t     life_tab[SLOTS];
    bit [6:0]  parent_tab[SLOTS];
    bit [15:0] tick_tab[SLOTS];
    bit        killed_tab[SLOTS];
    bit [15:0] chan_tab[SLOTS];
    bit [15:0] next_pid;
    int        cur_slot;
    bit [7:0]  slice_left;
    bit [7:0]  slice_len;
    rsp_t      pending[$];
    int        errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        pid_tab[i] = 0;
        life_tab[i] = LIFE_UNUSED;
        parent_tab[i] = 0;
        tick_tab[i] = 0;
        killed_tab[i] = 0;
        chan_tab[i] = 0;
      end
      pid_tab[0] = 1;
      life_tab[0] = LIFE_RUNNING;
      tick_tab[0] = BASE_TICKETS_RST;
      next_pid = NEXT_ID_RST;
      cur_slot = 0;
      slice_left = 0;
      slice_len = SLICE_LENGTH_RST;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Lowest in-use slot holding the pid; pid zero never matches.
    function int find_slot(bit [15:0] p);
      if (p == 0) return -1;
      for (int i = 0; i < SLOTS; i++)
        if (life_tab[i] != LIFE_UNUSED && pid_tab[i] == p) return i;
      return -1;
    endfunction

    function void wake(bit [15:0] ch);
      for (int i = 0; i < SLOTS; i++)
        if (life_tab[i] == LIFE_SLEEPING && chan_tab[i] == ch) life_tab[i] = LIFE_RUNNABLE;
    endfunction

    // Draws the next running slot; returns whether a winner was chosen.
    function bit run_lottery(bit [30:0] rnd);
      longint unsigned total, w;
      total = 0;
      slice_left = slice_len;
      if (life_tab[cur_slot] == LIFE_RUNNING) life_tab[cur_slot] = LIFE_RUNNABLE;
      for (int i = 0; i < SLOTS; i++)
        if (pid_tab[i] != 0 && !killed_tab[i] &&
            (life_tab[i] == LIFE_RUNNABLE || life_tab[i] == LIFE_RUNNING))
          total += tick_tab[i];
      if (total == 0) return 0;
      w = longint'(rnd) % total;
      for (int i = 0; i < SLOTS; i++) begin
        if (life_tab[i] != LIFE_RUNNABLE || killed_tab[i]) continue;
        if (w < tick_tab[i]) begin
          cur_slot = i;
          life_tab[i] = LIFE_RUNNING;
          return 1;
        end
        w -= tick_tab[i];
      end
      return 0;
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function void note_request(req_t r);
      rsp_t e;
      int s, c;
      bit kids;
      e = '0;
      e.status = ST_OK;
      s = find_slot(r.target_pid);
      case (r.req_type)
        REQ_TICK: begin
          if (slice_left <= 1) e.drew_lottery = run_lottery(r.random_value);
          else slice_left--;
        end
        REQ_FORK: begin
          c = -1;
          for (int i = 0; i < SLOTS; i++)
            if (c < 0 && life_tab[i] == LIFE_UNUSED) c = i;
          if (s < 0) e.status = ST_NOT_FOUND;
          else if (c < 0) e.status = ST_TABLE_FULL;
          else begin
            if (next_pid == 0) next_pid = 1;
            pid_tab[c] = next_pid;
            e.result_pid = next_pid;
            next_pid++;
            life_tab[c] = LIFE_RUNNABLE;
            parent_tab[c] = s + 1;
            tick_tab[c] = tick_tab[s];
            killed_tab[c] = 0;
            chan_tab[c] = 0;
            slice_left = 0;
            e.drew_lottery = run_lottery(r.random_value);
          end
        end
        REQ_EXIT: begin
          if (s < 0) e.status = ST_NOT_FOUND;
          else if (s == 0) e.status = ST_INIT_EXIT;
          else begin
            if (parent_tab[s] != 0) wake(pid_tab[parent_tab[s] - 1]);
            // Orphans become zombies owned by the first slot.
            for (int i = 0; i < SLOTS; i++)
              if (life_tab[i] != LIFE_UNUSED && parent_tab[i] == s + 1) begin
                parent_tab[i] = 1;
                life_tab[i] = LIFE_ZOMBIE;
              end
            life_tab[s] = LIFE_ZOMBIE;
            slice_left = 0;
            e.drew_lottery = run_lottery(r.random_value);
          end
        end
        REQ_WAIT: begin
          kids = 0;
          c = -1;
          if (s < 0) e.status = ST_NOT_FOUND;
          else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (life_tab[i] == LIFE_UNUSED || parent_tab[i] != s + 1) continue;
              kids = 1;
              if (life_tab[i] == LIFE_ZOMBIE) begin
                c = i;
                break;
              end
            end
            if (c >= 0) begin
              e.result_pid = pid_tab[c];
              life_tab[c] = LIFE_UNUSED;
              pid_tab[c] = 0;
              parent_tab[c] = 0;
              killed_tab[c] = 0;
            end else if (!kids || killed_tab[s]) begin
              e.status = ST_NO_CHILDREN;
            end else begin
              chan_tab[s] = pid_tab[s];
              life_tab[s] = LIFE_SLEEPING;
              slice_left = 0;
              e.drew_lottery = run_lottery(r.random_value);
              e.status = ST_CHILDREN_RUNNING;
            end
          end
        end
        REQ_SLEEP: begin
          if (s < 0) e.status = ST_NOT_FOUND;
          else begin
            chan_tab[s] = r.channel;
            life_tab[s] = LIFE_SLEEPING;
            slice_left = 0;
            e.drew_lottery = run_lottery(r.random_value);
          end
        end
        REQ_WAKEUP: begin
          wake(r.channel);
          slice_left = 0;
          e.drew_lottery = run_lottery(r.random_value);
        end
        REQ_KILL: begin
          if (s < 0) e.status = ST_NOT_FOUND;
          else begin
            killed_tab[s] = 1;
            if (life_tab[s] == LIFE_SLEEPING) life_tab[s] = LIFE_RUNNABLE;
          end
        end
        default: begin
          if (r.ticket_value == 0) e.status = ST_BAD_TICKETS;
          else if (s < 0) e.status = ST_NOT_FOUND;
          else tick_tab[s] = r.ticket_value;
        end
      endcase
      if (life_tab[cur_slot] == LIFE_RUNNING) e.running_pid = pid_tab[cur_slot];
      pending.push_back(e);
    endfunction

    // Compares one accepted response with the oldest expectation.
    task check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report("response with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.result_pid !== e.result_pid)
        report($sformatf("result_pid %0d, expected %0d", got.result_pid, e.result_pid));
      if (got.running_pid !== e.running_pid)
        report($sformatf("running_pid %0d, expected %0d", got.running_pid, e.running_pid));
      if (got.drew_lottery !== e.drew_lottery)
        report($sformatf("drew_lottery %0b, expected %0b", got.drew_lottery, e.drew_lottery));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sched_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  process_table_lottery_scheduler_core DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off counted down here.
  initial begin
    rsp_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall = 1;
        hold_left--;
      end else begin
        rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Check each response transfer.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Offers one request and returns after its transfer, at a falling edge.
  task send_request(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 0;
      @(negedge clk);
    end
    req_valid = 1;
    req = r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Wait until every response is in and the block has gone quiet.
  task drain();
    req_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLICE_LENGTH) sb.slice_len = val[7:0];
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function req_t make_req(req_code_t op, bit [15:0] p, bit [15:0] ch, bit [15:0] tv,
                          bit [30:0] rnd);
    req_t r;
    r.req_type = op;
    r.target_pid = p;
    r.channel = ch;
    r.ticket_value = tv;
    r.random_value = rnd;
    return r;
  endfunction

  function bit [15:0] live_pid();
    int slots[$];
    for (int i = 0; i < SLOTS; i++)
      if (sb.life_tab[i] != LIFE_UNUSED) slots.push_back(i);
    return sb.pid_tab[slots[$urandom_range(0, slots.size() - 1)]];
  endfunction

  // Random request aimed mostly at live entries; fork_pct raises fork pressure.
  function req_t random_request(int fork_pct);
    req_code_t op;
    bit [15:0] p, ch, tv;
    bit [30:0] rnd;
    int roll;
    if ($urandom_range(0, 99) < fork_pct) op = REQ_FORK;
    else begin
      case ($urandom_range(0, 8))
        0, 1: op = REQ_TICK;
        2: op = REQ_EXIT;
        3: op = REQ_WAIT;
        4: op = REQ_SLEEP;
        5: op = REQ_WAKEUP;
        6: op = REQ_KILL;
        default: op = REQ_SET_TICKETS;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (roll < 85) p = live_pid();
    else if (roll < 90) p = 0;
    else p = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) ch = live_pid();
    else if (roll < 70) ch = $urandom_range(0, 3);
    else ch = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 5) tv = 0;
    else if (roll < 75) tv = $urandom_range(1, 40);
    else tv = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 5) rnd = 0;
    else if (roll < 10) rnd = 31'h7FFFFFFF;
    else rnd = $urandom;
    return make_req(op, p, ch, tv, rnd);
  endfunction

  initial begin
    req_t directed[$];
    int slice_set[6] = '{1, 255, 0, 3, 10, 2};
    int idle_set[6] = '{0, 48, 0, 32, 0, 48};
    int stall_set[6] = '{0, 0, 48, 32, 48, 0};
    int fork_set[6] = '{15, 15, 15, 15, 60, 15};
    int deft_set[6] = '{1, 65535, 10, 7, 300, 2};
    sb = new();
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = CFG_BASE_TICKETS;
    cfg_data = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_reg(CFG_BASE_TICKETS, 16'hFFFF);
    write_reg(CFG_SLICE_LENGTH, 8'd10);

    // Directed: field extremes, every request, the named corner cases.
    directed.push_back(make_req(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(make_req(REQ_SET_TICKETS, 1, 0, 0, 0));
    directed.push_back(make_req(REQ_SET_TICKETS, 16'hFFFF, 0, 5, 0));
    directed.push_back(make_req(REQ_SET_TICKETS, 1, 0, 16'hFFFF, 0));
    directed.push_back(make_req(REQ_FORK, 1, 0, 0, 31'h7FFFFFFF));
    directed.push_back(make_req(REQ_FORK, 2, 0, 0, 12345));
    directed.push_back(make_req(REQ_FORK, 0, 0, 0, 0));
    directed.push_back(make_req(REQ_TICK, 0, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF));
    directed.push_back(make_req(REQ_SLEEP, 3, 16'hFFFF, 0, 7));
    directed.push_back(make_req(REQ_WAKEUP, 0, 16'hFFFF, 0, 31'h7FFFFFFF));
    directed.push_back(make_req(REQ_WAIT, 2, 0, 0, 3));
    directed.push_back(make_req(REQ_EXIT, 3, 0, 0, 99));
    directed.push_back(make_req(REQ_WAIT, 2, 0, 0, 0));
    directed.push_back(make_req(REQ_WAIT, 2, 0, 0, 0));
    directed.push_back(make_req(REQ_EXIT, 1, 0, 0, 0));
    directed.push_back(make_req(REQ_KILL, 2, 0, 0, 0));
    directed.push_back(make_req(REQ_KILL, 0, 0, 0, 0));
    directed.push_back(make_req(REQ_WAIT, 1, 0, 0, 5));
    directed.push_back(make_req(REQ_FORK, 2, 0, 0, 8));
    directed.push_back(make_req(REQ_SLEEP, 4, 0, 0, 1));
    directed.push_back(make_req(REQ_KILL, 4, 0, 0, 0));
    directed.push_back(make_req(REQ_EXIT, 2, 0, 0, 2));
    directed.push_back(make_req(REQ_WAKEUP, 0, 0, 0, 0));
    directed.push_back(make_req(REQ_SET_TICKETS, 1, 0, 1, 0));
    foreach (directed[i]) send_request(directed[i]);

    // Random phases under different settings and idling mixes.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BASE_TICKETS, deft_set[ph]);
      write_reg(CFG_SLICE_LENGTH, slice_set[ph]);
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      // Long receiver hold-off so the block backs up into its input.
      if (ph == 2) hold_left = 800;
      for (int n = 0; n < 270; n++) begin
        if (ph == 3 && n == 135) drain();
        send_request(random_request(fork_set[ph]));
      end
    end

    req_valid = 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.pending.size() != 0) sb.report("expected responses never arrived");
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #50000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
src/ptls_pkg.sv
src/ptls_table.sv
src/ptls_mod.sv
src/process_table_lottery_scheduler_core.sv
sim/process_table_lottery_scheduler_core_test.sv
